### rtl/utf8_whitespace_tokenizer_assert.svh
// Assertion macros for the UTF-8 whitespace tokenizer.
// No dependencies; included by the files that assert.
`ifndef UTF8_WHITESPACE_TOKENIZER_ASSERT_SVH
`define UTF8_WHITESPACE_TOKENIZER_ASSERT_SVH

// Property holds in the same cycle as its trigger.
`define UWT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("uwt assertion failed");

// Property holds in the cycle after its trigger.
`define UWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("uwt assertion failed");

`endif

### rtl/uwt_pkg.sv
// Package for the UTF-8 whitespace tokenizer: result types, codes, constants.
// No dependencies.
package uwt_pkg;

	localparam int OFFSET_WIDTH_DEF = 24;
	localparam int OFF_W            = 24;
	localparam int CNT_W            = 24;
	localparam int CP_W             = 21;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// lead byte tags
	localparam logic [2:0] LEAD2_TAG = 3'h6;
	localparam logic [3:0] LEAD3_TAG = 4'hE;
	localparam logic [4:0] LEAD4_TAG = 5'h1E;

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_TOKEN_END = 2'd1,
		KIND_ERROR     = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_ILLEGAL   = 2'd1,
		ERR_TRUNCATED = 2'd2
	} err_t;

	typedef struct packed {
		kind_t             kind;
		logic [CP_W-1:0]   code_point;
		logic [OFF_W-1:0]  byte_offset;
		logic [CNT_W-1:0]  token_count;
		err_t              error_code;
		logic              last_in_run;
	} result_t;

	// space, tab, LF, CR
	function automatic logic is_ws(input logic [CP_W-1:0] cp);
		return cp == CP_W'(32'h20) || cp == CP_W'(32'h09) ||
			cp == CP_W'(32'h0A) || cp == CP_W'(32'h0D);
	endfunction

endpackage

### rtl/utf8_whitespace_tokenizer.sv
// UTF-8 whitespace tokenizer: decoder, token tracking, 4-entry result buffer.
// Depends on uwt_pkg and utf8_whitespace_tokenizer_assert.svh.
// A byte waits in the input register until the buffer has room for two results;
// its results are written into the buffer that drives out_valid. Throughput: one
// byte per cycle while the buffer has room; it absorbs a character plus the token
// end at end of text. Reset (arst_n low) clears all control state at once.
`include "utf8_whitespace_tokenizer_assert.svh"

module utf8_whitespace_tokenizer
	import uwt_pkg::*;
#(
	parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	input  logic             end_of_input,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [CP_W-1:0]  code_point,
	output logic [OFF_W-1:0] byte_offset,
	output logic [CNT_W-1:0] token_count,
	output logic [1:0]       error_code,
	output logic             last_in_run
);

	localparam int EXT_W   = OFFSET_WIDTH + OFF_W;
	localparam int DEPTH   = 4;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int LEVEL_W = PTR_W + 1;

	// ---------------- input register ----------------
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       end_of_input_s1;
	logic       process;

	// ---------------- decoder / token state ----------------
	logic                    inside_token_q, inside_token_n;
	logic [OFFSET_WIDTH-1:0] token_start_q, token_start_n;
	logic [CNT_W-1:0]        chars_q, chars_n;
	logic [OFFSET_WIDTH-1:0] byte_counter_q;
	logic [1:0]              pending_q, pending_n;
	logic [CP_W-1:0]         partial_q, partial_n;
	logic [OFFSET_WIDTH-1:0] char_start_q, char_start_n;
	logic                    error_seen_q, error_seen_n;

	// results of the byte in the input register
	result_t res_a, res_b;
	logic    res_a_v, res_b_v;
	result_t slot0, slot1;
	logic [1:0] n_res;

	// ---------------- result buffer ----------------
	result_t            buf_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [LEVEL_W-1:0] level_q;
	logic               pop;
	result_t            head;

	// The byte in the input register is processed once the buffer surely has
	// room for two results; a new byte is taken in the same cycle.
	assign process  = valid_s1 && (level_q <= LEVEL_W'(DEPTH - 2));
	assign in_ready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_byte_s1    <= data_byte;
			end_of_input_s1 <= end_of_input;
		end
	end

	// Decode one byte, update token tracking and build up to two results:
	// res_a is a character, token end or illegal-lead error; res_b is the
	// end-of-text token end or truncation error.
	always_comb begin : decode
		logic [EXT_W-1:0] ext;
		logic [CP_W-1:0]  cp;
		logic             done;
		logic             illegal;
		logic [CNT_W-1:0] idx;

		ext            = '0;
		cp             = '0;
		done           = 1'b0;
		illegal        = 1'b0;
		idx            = '0;
		inside_token_n = inside_token_q;
		token_start_n  = token_start_q;
		chars_n        = chars_q;
		pending_n      = pending_q;
		partial_n      = partial_q;
		char_start_n   = char_start_q;
		error_seen_n   = error_seen_q;
		res_a          = '0;
		res_b          = '0;
		res_a_v        = 1'b0;
		res_b_v        = 1'b0;

		if (!error_seen_q) begin
			if (pending_q != 2'd0) begin
				// continuation byte, low six bits taken unchecked
				partial_n = {partial_q[CP_W-7:0], data_byte_s1[5:0]};
				pending_n = pending_q - 2'd1;
				done      = (pending_q == 2'd1);
				cp        = partial_n;
			end else begin
				char_start_n = byte_counter_q;
				if (!data_byte_s1[7]) begin
					done = 1'b1;
					cp   = CP_W'(data_byte_s1);
				end else if (data_byte_s1[7:5] == LEAD2_TAG) begin
					partial_n = CP_W'(data_byte_s1[4:0]);
					pending_n = 2'd1;
				end else if (data_byte_s1[7:4] == LEAD3_TAG) begin
					partial_n = CP_W'(data_byte_s1[3:0]);
					pending_n = 2'd2;
				end else if (data_byte_s1[7:3] == LEAD4_TAG) begin
					partial_n = CP_W'(data_byte_s1[2:0]);
					pending_n = 2'd3;
				end else begin
					illegal      = 1'b1;
					error_seen_n = 1'b1;
				end
			end

			if (done) begin
				if (is_ws(cp)) begin
					if (inside_token_q) begin
						ext               = {{OFF_W{1'b0}}, token_start_q};
						res_a_v           = 1'b1;
						res_a.kind        = KIND_TOKEN_END;
						res_a.byte_offset = ext[OFF_W-1:0];
						res_a.token_count = chars_q;
						res_a.error_code  = ERR_NONE;
						inside_token_n    = 1'b0;
						chars_n           = '0;
					end
				end else begin
					if (!inside_token_q) begin
						inside_token_n = 1'b1;
						token_start_n  = char_start_n;
						idx            = '0;
					end else begin
						idx = chars_q;
					end
					ext               = {{OFF_W{1'b0}}, char_start_n};
					res_a_v           = 1'b1;
					res_a.kind        = KIND_CHAR;
					res_a.code_point  = cp;
					res_a.byte_offset = ext[OFF_W-1:0];
					res_a.token_count = idx;
					res_a.error_code  = ERR_NONE;
					chars_n           = (idx == COUNT_MAX) ? idx : idx + CNT_W'(1);
				end
			end

			if (illegal) begin
				ext               = {{OFF_W{1'b0}}, byte_counter_q};
				res_a_v           = 1'b1;
				res_a.kind        = KIND_ERROR;
				res_a.byte_offset = ext[OFF_W-1:0];
				res_a.error_code  = ERR_ILLEGAL;
			end

			if (end_of_input_s1 && !error_seen_n) begin
				if (pending_n != 2'd0) begin
					// text ends inside a sequence
					ext               = {{OFF_W{1'b0}}, char_start_n};
					res_b_v           = 1'b1;
					res_b.kind        = KIND_ERROR;
					res_b.byte_offset = ext[OFF_W-1:0];
					res_b.error_code  = ERR_TRUNCATED;
				end else if (inside_token_n) begin
					ext               = {{OFF_W{1'b0}}, token_start_n};
					res_b_v           = 1'b1;
					res_b.kind        = KIND_TOKEN_END;
					res_b.byte_offset = ext[OFF_W-1:0];
					res_b.token_count = chars_n;
					res_b.error_code  = ERR_NONE;
				end
			end
		end
	end

	// Pack the results in order; the final one carries last_in_run.
	always_comb begin
		slot0 = res_a_v ? res_a : res_b;
		slot1 = res_b;
		n_res = 2'(res_a_v) + 2'(res_b_v);
		slot0.last_in_run = (n_res == 2'd1);
		slot1.last_in_run = 1'b1;
	end

	// State update; end of text returns everything to the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_token_q <= 1'b0;
			token_start_q  <= '0;
			chars_q        <= '0;
			byte_counter_q <= '0;
			pending_q      <= 2'd0;
			partial_q      <= '0;
			char_start_q   <= '0;
			error_seen_q   <= 1'b0;
		end else if (process) begin
			if (end_of_input_s1) begin
				inside_token_q <= 1'b0;
				token_start_q  <= '0;
				chars_q        <= '0;
				byte_counter_q <= '0;
				pending_q      <= 2'd0;
				partial_q      <= '0;
				char_start_q   <= '0;
				error_seen_q   <= 1'b0;
			end else begin
				inside_token_q <= inside_token_n;
				token_start_q  <= token_start_n;
				chars_q        <= chars_n;
				pending_q      <= pending_n;
				partial_q      <= partial_n;
				char_start_q   <= char_start_n;
				error_seen_q   <= error_seen_n;
				// offset saturates at its all-ones value
				if (byte_counter_q != {OFFSET_WIDTH{1'b1}}) begin
					byte_counter_q <= byte_counter_q + OFFSET_WIDTH'(1);
				end
			end
		end
	end

	// ---------------- result buffer ----------------
	assign pop  = out_valid && out_ready;
	assign head = buf_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (process) begin
			if (n_res != 2'd0) begin
				buf_q[wr_ptr_q] <= slot0;
			end
			if (n_res == 2'd2) begin
				buf_q[wr_ptr_q + PTR_W'(1)] <= slot1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (process) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			level_q <= level_q + (process ? LEVEL_W'(n_res) : LEVEL_W'(0))
				- LEVEL_W'(pop);
		end
	end

	assign out_valid   = (level_q != '0);
	assign kind        = head.kind;
	assign code_point  = head.code_point;
	assign byte_offset = head.byte_offset;
	assign token_count = head.token_count;
	assign error_code  = head.error_code;
	assign last_in_run = head.last_in_run;

	// ---------------- assertions ----------------
	`UWT_ASSERT_NOW(a_level_bound, clk, arst_n, 1'b1, level_q <= LEVEL_W'(DEPTH))
	`UWT_ASSERT_NOW(a_no_pend_in_err, clk, arst_n, pending_q != 2'd0, !error_seen_q)
	`UWT_ASSERT_NOW(a_count_outside, clk, arst_n, !inside_token_q, chars_q == '0)
	`UWT_ASSERT_NEXT(a_eoi_reset, clk, arst_n, process && end_of_input_s1,
		byte_counter_q == '0 && !inside_token_q && !error_seen_q)

endmodule
